// File: src/nfts_pkg.sv
// ----------------------------------------------------------------------------
// Nearest four toroidal select package
// Shared types and fixed constants of the nearest-four selection block.
// ----------------------------------------------------------------------------
package nfts_pkg;

    localparam int unsigned SLOT_COUNT = 4;
    localparam int unsigned COUNT_BITS = 3;
    localparam int unsigned FIELD_WIDTH_RST = 12800;
    localparam int unsigned FIELD_HEIGHT_RST = 9600;
    localparam int unsigned APB_DATA_BITS = 32;
    localparam int unsigned APB_ADDR_BITS = 3;

    typedef enum logic {
        REG_FIELD_WIDTH  = 1'b0,
        REG_FIELD_HEIGHT = 1'b1
    } t_reg_idx;

    typedef struct packed {
        logic valid;
        logic last;
    } t_stage_ctl;

endpackage

// File: src/nfts_cfg.sv
// ----------------------------------------------------------------------------
// Configuration registers
// APB-style register file holding the wrap width and height of the field.
// ----------------------------------------------------------------------------
module nfts_cfg
    import nfts_pkg::*;
#(
    parameter int unsigned COORD_BITS
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [APB_ADDR_BITS-1:0]  paddr,
    input  logic [APB_DATA_BITS-1:0]  pwdata,
    output logic [APB_DATA_BITS-1:0]  prdata,
    output logic                      pready,
    output logic [COORD_BITS-1:0]     o_field_width,
    output logic [COORD_BITS-1:0]     o_field_height
);

    logic [COORD_BITS-1:0] r_field_width;
    logic [COORD_BITS-1:0] r_field_height;
    logic [COORD_BITS-1:0] rd_value;
    t_reg_idx              reg_idx;
    logic                  wr_en;

    assign pready  = 1'b1;
    assign reg_idx = t_reg_idx'(paddr[2]);
    assign wr_en   = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_field_width  <= COORD_BITS'(FIELD_WIDTH_RST);
            r_field_height <= COORD_BITS'(FIELD_HEIGHT_RST);
        end else if (wr_en) begin
            unique case (reg_idx)
                REG_FIELD_WIDTH: begin
                    r_field_width <= pwdata[COORD_BITS-1:0];
                end
                REG_FIELD_HEIGHT: begin
                    r_field_height <= pwdata[COORD_BITS-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_FIELD_WIDTH:  rd_value = r_field_width;
            REG_FIELD_HEIGHT: rd_value = r_field_height;
            default:          rd_value = '0;
        endcase
    end

    assign prdata         = {{(APB_DATA_BITS-COORD_BITS){1'b0}}, rd_value};
    assign o_field_width  = r_field_width;
    assign o_field_height = r_field_height;

endmodule

// File: src/nfts_axis.sv
// ----------------------------------------------------------------------------
// Wrap-around axis offset
// Symmetric toroidal offset between two coordinates on one axis.
// ----------------------------------------------------------------------------
module nfts_axis #(
    parameter int unsigned COORD_BITS
) (
    input  logic [COORD_BITS-1:0] i_a,
    input  logic [COORD_BITS-1:0] i_b,
    input  logic [COORD_BITS-1:0] i_size,
    output logic [COORD_BITS-1:0] o_offset
);

    logic [COORD_BITS-1:0] direct;
    logic [COORD_BITS-1:0] wrapped;

    always_comb begin
        direct   = (i_a >= i_b) ? (i_a - i_b) : (i_b - i_a);
        wrapped  = i_size - direct;
        // The wrap only applies when the direct offset lies inside the field.
        o_offset = ((direct < i_size) && (wrapped < direct)) ? wrapped : direct;
    end

endmodule

// File: src/nfts_dist.sv
// ----------------------------------------------------------------------------
// Distance pipeline
// Input register, wrapped axis offsets and registered squares per beat.
// ----------------------------------------------------------------------------
module nfts_dist
    import nfts_pkg::*;
#(
    parameter int unsigned ID_BITS,
    parameter int unsigned COORD_BITS
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    output logic                      o_in_stall,
    input  logic [ID_BITS-1:0]        i_object_id,
    input  logic [COORD_BITS-1:0]     i_object_x,
    input  logic [COORD_BITS-1:0]     i_object_y,
    input  logic [COORD_BITS-1:0]     i_ref_x,
    input  logic [COORD_BITS-1:0]     i_ref_y,
    input  logic                      i_scan_end,
    input  logic [COORD_BITS-1:0]     i_field_width,
    input  logic [COORD_BITS-1:0]     i_field_height,
    input  logic                      i_take,
    output t_stage_ctl                o_ctl,
    output logic [ID_BITS-1:0]        o_ident,
    output logic [2*COORD_BITS-1:0]   o_sq_x,
    output logic [2*COORD_BITS-1:0]   o_sq_y
);

    localparam int unsigned SQ_BITS = 2 * COORD_BITS;

    t_stage_ctl              r_s1_ctl;
    logic [ID_BITS-1:0]      r_s1_id;
    logic [COORD_BITS-1:0]   r_s1_ox;
    logic [COORD_BITS-1:0]   r_s1_oy;
    logic [COORD_BITS-1:0]   r_s1_rx;
    logic [COORD_BITS-1:0]   r_s1_ry;

    t_stage_ctl              r_s2_ctl;
    logic [ID_BITS-1:0]      r_s2_id;
    logic [COORD_BITS-1:0]   r_s2_dx;
    logic [COORD_BITS-1:0]   r_s2_dy;

    t_stage_ctl              r_s3_ctl;
    logic [ID_BITS-1:0]      r_s3_id;
    logic [SQ_BITS-1:0]      r_s3_sqx;
    logic [SQ_BITS-1:0]      r_s3_sqy;

    logic [COORD_BITS-1:0]   off_x;
    logic [COORD_BITS-1:0]   off_y;
    logic                    adv1;
    logic                    adv2;
    logic                    adv3;

    assign adv3       = !r_s3_ctl.valid || i_take;
    assign adv2       = !r_s2_ctl.valid || adv3;
    assign adv1       = !r_s1_ctl.valid || adv2;
    assign o_in_stall = !adv1;

    nfts_axis #(.COORD_BITS(COORD_BITS)) u_axis_x (
        .i_a      (r_s1_ox),
        .i_b      (r_s1_rx),
        .i_size   (i_field_width),
        .o_offset (off_x)
    );

    nfts_axis #(.COORD_BITS(COORD_BITS)) u_axis_y (
        .i_a      (r_s1_oy),
        .i_b      (r_s1_ry),
        .i_size   (i_field_height),
        .o_offset (off_y)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_ctl <= '0;
            r_s2_ctl <= '0;
            r_s3_ctl <= '0;
        end else begin
            if (adv1) begin
                r_s1_ctl.valid <= i_in_valid;
                r_s1_ctl.last  <= i_scan_end;
            end
            if (adv2) begin
                r_s2_ctl <= r_s1_ctl;
            end
            if (adv3) begin
                r_s3_ctl <= r_s2_ctl;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv1) begin
            r_s1_id <= i_object_id;
            r_s1_ox <= i_object_x;
            r_s1_oy <= i_object_y;
            r_s1_rx <= i_ref_x;
            r_s1_ry <= i_ref_y;
        end
        if (adv2) begin
            r_s2_id <= r_s1_id;
            r_s2_dx <= off_x;
            r_s2_dy <= off_y;
        end
        if (adv3) begin
            r_s3_id  <= r_s2_id;
            r_s3_sqx <= SQ_BITS'(r_s2_dx) * SQ_BITS'(r_s2_dx);
            r_s3_sqy <= SQ_BITS'(r_s2_dy) * SQ_BITS'(r_s2_dy);
        end
    end

    assign o_ctl   = r_s3_ctl;
    assign o_ident = r_s3_id;
    assign o_sq_x  = r_s3_sqx;
    assign o_sq_y  = r_s3_sqy;

endmodule

// File: src/nfts_list.sv
// ----------------------------------------------------------------------------
// Nearest list and result register
// Sorted four-slot list with shift-insert update and the result register.
// ----------------------------------------------------------------------------
module nfts_list
    import nfts_pkg::*;
#(
    parameter int unsigned ID_BITS,
    parameter int unsigned COORD_BITS
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  t_stage_ctl                            i_ctl,
    input  logic [ID_BITS-1:0]                    i_ident,
    input  logic [2*COORD_BITS-1:0]               i_sq_x,
    input  logic [2*COORD_BITS-1:0]               i_sq_y,
    output logic                                  o_take,
    output logic                                  o_out_valid,
    input  logic                                  i_out_stall,
    output logic [SLOT_COUNT-1:0][ID_BITS-1:0]    o_ident,
    output logic [COUNT_BITS-1:0]                 o_found_count
);

    localparam int unsigned DIST_BITS = 2 * COORD_BITS + 1;

    logic [SLOT_COUNT-1:0][DIST_BITS-1:0]  r_dist;
    logic [SLOT_COUNT-1:0][ID_BITS-1:0]    r_id;
    logic [SLOT_COUNT-1:0]                 r_valid;
    logic [SLOT_COUNT-1:0][DIST_BITS-1:0]  n_dist;
    logic [SLOT_COUNT-1:0][ID_BITS-1:0]    n_id;
    logic [SLOT_COUNT-1:0]                 n_valid;

    logic                                  r_out_valid;
    logic [SLOT_COUNT-1:0][ID_BITS-1:0]    r_out_id;
    logic [COUNT_BITS-1:0]                 r_out_count;

    logic [DIST_BITS-1:0]                  cand_dist;
    logic [SLOT_COUNT-1:0]                 lt;
    logic                                  fire;
    logic                                  fire_last;

    assign cand_dist = DIST_BITS'(i_sq_x) + DIST_BITS'(i_sq_y);
    assign o_take    = !(i_ctl.last && r_out_valid && i_out_stall);
    assign fire      = i_ctl.valid && o_take;
    assign fire_last = fire && i_ctl.last;

    always_comb begin
        for (int k = 0; k < SLOT_COUNT; k++) begin
            lt[k] = !r_valid[k] || (cand_dist < r_dist[k]);
        end
        // The list is sorted, so lt is false over a prefix and true after it.
        if (lt[0]) begin
            n_dist[0]  = cand_dist;
            n_id[0]    = i_ident;
            n_valid[0] = 1'b1;
        end else begin
            n_dist[0]  = r_dist[0];
            n_id[0]    = r_id[0];
            n_valid[0] = r_valid[0];
        end
        for (int k = 1; k < SLOT_COUNT; k++) begin
            if (lt[k-1]) begin
                n_dist[k]  = r_dist[k-1];
                n_id[k]    = r_id[k-1];
                n_valid[k] = r_valid[k-1];
            end else if (lt[k]) begin
                n_dist[k]  = cand_dist;
                n_id[k]    = i_ident;
                n_valid[k] = 1'b1;
            end else begin
                n_dist[k]  = r_dist[k];
                n_id[k]    = r_id[k];
                n_valid[k] = r_valid[k];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (fire) begin
                r_valid <= fire_last ? '0 : n_valid;
            end
            if (fire_last) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_dist <= n_dist;
            r_id   <= n_id;
        end
        if (fire_last) begin
            for (int k = 0; k < SLOT_COUNT; k++) begin
                r_out_id[k] <= n_valid[k] ? n_id[k] : '0;
            end
            r_out_count <= COUNT_BITS'($countones(n_valid));
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_ident       = r_out_id;
    assign o_found_count = r_out_count;

`ifndef SYNTHESIS
    a_valid_prefix: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!r_valid[1] || r_valid[0]) && (!r_valid[2] || r_valid[1]) &&
        (!r_valid[3] || r_valid[2]))
        else $error("Slot valid bits are not a prefix.");

    a_sorted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!r_valid[1] || (r_dist[0] <= r_dist[1])) &&
        (!r_valid[2] || (r_dist[1] <= r_dist[2])) &&
        (!r_valid[3] || (r_dist[2] <= r_dist[3])))
        else $error("Nearest list is out of order.");

    a_clear_on_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fire_last |=> (r_valid == '0) && r_out_valid)
        else $error("List not cleared or result missing after scan end.");

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out_count <= COUNT_BITS'(SLOT_COUNT)))
        else $error("Found count exceeds the slot count.");
`endif

endmodule

// File: src/nearest_four_toroidal_select_core.sv
// A result beat is valid once the accepted scan_end beat has updated the list.
// Throughput: one input beat per cycle; a stalled result holds the pipeline once
// the next scan_end beat reaches the list.
// The pipeline is input register, offset register, square register, then list update.
// Reset (i_rst_n low, synchronous) empties the list and the pipeline.
// Reset loads the field width with 12800 and the field height with 9600.
// ----------------------------------------------------------------------------
// Nearest four toroidal select core
// Streams candidate objects and reports up to four nearest on a wrapped field.
// ----------------------------------------------------------------------------
module nearest_four_toroidal_select_core
    import nfts_pkg::*;
#(
    parameter int unsigned ID_BITS    = 8,
    parameter int unsigned COORD_BITS = 16
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [APB_ADDR_BITS-1:0]  paddr,
    input  logic [APB_DATA_BITS-1:0]  pwdata,
    output logic [APB_DATA_BITS-1:0]  prdata,
    output logic                      pready,
    input  logic                      i_in_valid,
    output logic                      o_in_stall,
    input  logic [ID_BITS-1:0]        i_object_id,
    input  logic [COORD_BITS-1:0]     i_object_x,
    input  logic [COORD_BITS-1:0]     i_object_y,
    input  logic [COORD_BITS-1:0]     i_ref_x,
    input  logic [COORD_BITS-1:0]     i_ref_y,
    input  logic                      i_scan_end,
    output logic                      o_out_valid,
    input  logic                      i_out_stall,
    output logic [ID_BITS-1:0]        o_nearest_first,
    output logic [ID_BITS-1:0]        o_nearest_second,
    output logic [ID_BITS-1:0]        o_nearest_third,
    output logic [ID_BITS-1:0]        o_nearest_fourth,
    output logic [COUNT_BITS-1:0]     o_found_count
);

    logic [COORD_BITS-1:0]               field_width;
    logic [COORD_BITS-1:0]               field_height;
    t_stage_ctl                          list_ctl;
    logic [ID_BITS-1:0]                  list_ident;
    logic [2*COORD_BITS-1:0]             list_sq_x;
    logic [2*COORD_BITS-1:0]             list_sq_y;
    logic                                list_take;
    logic [SLOT_COUNT-1:0][ID_BITS-1:0]  out_ident;

    nfts_cfg #(.COORD_BITS(COORD_BITS)) u_cfg (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .o_field_width  (field_width),
        .o_field_height (field_height)
    );

    nfts_dist #(.ID_BITS(ID_BITS), .COORD_BITS(COORD_BITS)) u_dist (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_object_id    (i_object_id),
        .i_object_x     (i_object_x),
        .i_object_y     (i_object_y),
        .i_ref_x        (i_ref_x),
        .i_ref_y        (i_ref_y),
        .i_scan_end     (i_scan_end),
        .i_field_width  (field_width),
        .i_field_height (field_height),
        .i_take         (list_take),
        .o_ctl          (list_ctl),
        .o_ident        (list_ident),
        .o_sq_x         (list_sq_x),
        .o_sq_y         (list_sq_y)
    );

    nfts_list #(.ID_BITS(ID_BITS), .COORD_BITS(COORD_BITS)) u_list (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_ctl          (list_ctl),
        .i_ident        (list_ident),
        .i_sq_x         (list_sq_x),
        .i_sq_y         (list_sq_y),
        .o_take         (list_take),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_ident        (out_ident),
        .o_found_count  (o_found_count)
    );

    assign o_nearest_first  = out_ident[0];
    assign o_nearest_second = out_ident[1];
    assign o_nearest_third  = out_ident[2];
    assign o_nearest_fourth = out_ident[3];

endmodule
